[hw/rtl/nru_pkg.sv]
package nru_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int ADDR_IN_W = 32;
    localparam int OFFSET_W = 6;
    localparam int MASK_W = 32;
    localparam int WAYS_CFG_W = 4;
    localparam int WAY_OUT_W = 3;
    localparam int SET_OUT_W = 10;

    localparam logic [OFFSET_W-1:0] OFFSET_RST = 6'd6;
    localparam logic [MASK_W-1:0] MASK_RST = 32'd65472;
    localparam logic [WAYS_CFG_W-1:0] WAYS_RST = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS = 2'd0,
        CFG_INDEX_MASK = 2'd1,
        CFG_WAYS_IN_USE = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN = 1'b1
    } state_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset_bits;
        logic [MASK_W-1:0] index_mask;
        logic [WAYS_CFG_W-1:0] ways_in_use;
    } cfg_t;

endpackage

[hw/rtl/nru_set_assoc_cache_lookup.sv]
// channel   direction  signals                               handshake
// -------   ---------  ------------------------------------  -----------------------
// item in   in         addr                                  start && !busy
// result    out        hit, way_used, set_number             done, one cycle
// config    in         cfg_index, cfg_data                   cfg_valid && cfg_ready
//
// one item per cycle while not busy; an item's result passes through the s1 registers, then the result registers
// set row is read on accept, compared and written back the cycle after
// same-set items back to back are served by a bypass in the set store
// after reset a clearing pass over all 2**SET_BITS sets holds busy high
// results cannot be held off; config is always taken
module nru_set_assoc_cache_lookup #(
    parameter int ADDR_BITS = 32,
    parameter int WAYS = 8,
    parameter int SET_BITS = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [nru_pkg::ADDR_IN_W-1:0]    addr,
    output logic                             done,
    output logic                             hit,
    output logic [nru_pkg::WAY_OUT_W-1:0]    way_used,
    output logic [nru_pkg::SET_OUT_W-1:0]    set_number,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [nru_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nru_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SET_W = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int SETS = 1 << SET_BITS;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NW_W = $clog2(WAYS + 1);
    localparam int TW = WAYS * ADDR_BITS;
    localparam int MW = 2 * WAYS;
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);

    nru_pkg::cfg_t   cfg_reg;
    nru_pkg::cfg_t   cfg_next;
    nru_pkg::state_t state_reg;
    nru_pkg::state_t state_next;
    logic [SET_W-1:0] clr_cnt_reg;
    logic [SET_W-1:0] clr_cnt_next;

    logic                 accept;
    logic [SET_W-1:0]     in_set;
    logic [ADDR_BITS-1:0] in_tag;

    logic                 s1_valid_reg;
    logic [SET_W-1:0]     s1_set_reg;
    logic [ADDR_BITS-1:0] s1_tag_reg;

    logic                 tag_we;
    logic                 meta_we;
    logic [SET_W-1:0]     wr_addr;
    logic [TW-1:0]        wr_tags;
    logic [MW-1:0]        wr_meta;
    logic [TW-1:0]        rd_tags;
    logic [MW-1:0]        rd_meta;

    logic [NW_W-1:0]               nw;
    logic                          up_hit;
    logic [WAY_W-1:0]              up_way;
    logic [WAYS-1:0][ADDR_BITS-1:0] up_tags;
    logic [WAYS-1:0]               up_valid;
    logic [WAYS-1:0]               up_nru;

    logic             done_reg;
    logic             hit_reg;
    logic [WAY_W-1:0] way_reg;
    logic [SET_W-1:0] set_reg;

    assign cfg_ready = 1'b1;
    assign busy = (state_reg == nru_pkg::ST_CLEAR);
    assign accept = start && !busy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (nru_pkg::cfg_reg_t'(cfg_index))
                nru_pkg::CFG_OFFSET_BITS:
                    cfg_next.offset_bits = cfg_data[nru_pkg::OFFSET_W-1:0];
                nru_pkg::CFG_INDEX_MASK:
                    cfg_next.index_mask = cfg_data[nru_pkg::MASK_W-1:0];
                nru_pkg::CFG_WAYS_IN_USE:
                    cfg_next.ways_in_use = cfg_data[nru_pkg::WAYS_CFG_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // ways in use, clamped to 1..WAYS
    always_comb
    begin
        if (cfg_reg.ways_in_use == '0)
        begin
            nw = NW_W'(1);
        end
        else if (int'(cfg_reg.ways_in_use) > WAYS)
        begin
            nw = NW_W'(WAYS);
        end
        else
        begin
            nw = NW_W'(cfg_reg.ways_in_use);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            nru_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + SET_W'(1);
                if (clr_cnt_reg == LAST_SET)
                begin
                    state_next = nru_pkg::ST_RUN;
                end
            end
            nru_pkg::ST_RUN:
            begin
                state_next = nru_pkg::ST_RUN;
            end
            default:
            begin
                state_next = nru_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nru_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            cfg_reg.offset_bits <= nru_pkg::OFFSET_RST;
            cfg_reg.index_mask <= nru_pkg::MASK_RST;
            cfg_reg.ways_in_use <= nru_pkg::WAYS_RST;
            s1_valid_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            cfg_reg <= cfg_next;
            s1_valid_reg <= accept;
            done_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_set_reg <= in_set;
            s1_tag_reg <= in_tag;
        end
        if (s1_valid_reg)
        begin
            hit_reg <= up_hit;
            way_reg <= up_way;
            set_reg <= s1_set_reg;
        end
    end

    nru_index #(
        .ADDR_BITS (ADDR_BITS),
        .SET_BITS  (SET_BITS),
        .SET_W     (SET_W)
    ) u_index (
        .addr    (addr),
        .cfg     (cfg_reg),
        .set_idx (in_set),
        .tag     (in_tag)
    );

    // clearing pass: all ways invalid, all nru bits set
    always_comb
    begin
        if (busy)
        begin
            tag_we = 1'b0;
            meta_we = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_meta = {{WAYS{1'b0}}, {WAYS{1'b1}}};
        end
        else
        begin
            tag_we = s1_valid_reg && !up_hit;
            meta_we = s1_valid_reg;
            wr_addr = s1_set_reg;
            wr_meta = {up_valid, up_nru};
        end
        wr_tags = up_tags;
    end

    nru_store #(
        .AW    (SET_W),
        .DEPTH (SETS),
        .TW    (TW),
        .MW    (MW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (in_set),
        .tag_we  (tag_we),
        .meta_we (meta_we),
        .wr_addr (wr_addr),
        .wr_tags (wr_tags),
        .wr_meta (wr_meta),
        .rd_tags (rd_tags),
        .rd_meta (rd_meta)
    );

    nru_update #(
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS),
        .WAY_W     (WAY_W),
        .NW_W      (NW_W)
    ) u_update (
        .tag       (s1_tag_reg),
        .tags_in   (rd_tags),
        .valid_in  (rd_meta[MW-1:WAYS]),
        .nru_in    (rd_meta[WAYS-1:0]),
        .nw        (nw),
        .hit       (up_hit),
        .way       (up_way),
        .tags_out  (up_tags),
        .valid_out (up_valid),
        .nru_out   (up_nru)
    );

    assign done = done_reg;
    assign hit = hit_reg;
    assign way_used = nru_pkg::WAY_OUT_W'(way_reg);
    assign set_number = (SET_BITS > 0) ? nru_pkg::SET_OUT_W'(set_reg) : '0;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("item without result");

    a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s1_valid_reg && !done_reg)
        else $error("item in flight during clearing pass");

    a_way_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (int'(up_way) < int'(nw)))
        else $error("way outside ways in use");

    a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && clr_cnt_reg == LAST_SET) |=> !busy)
        else $error("clearing pass did not end");

    a_hit_keeps_tags: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && up_hit) |-> !tag_we)
        else $error("tag row written on a hit");

endmodule

[hw/rtl/nru_index.sv]
module nru_index #(
    parameter int ADDR_BITS = 32,
    parameter int SET_BITS = 10,
    parameter int SET_W = 10
) (
    input  logic [nru_pkg::ADDR_IN_W-1:0] addr,
    input  nru_pkg::cfg_t                 cfg,
    output logic [SET_W-1:0]              set_idx,
    output logic [ADDR_BITS-1:0]          tag
);

    localparam int GW = (ADDR_BITS < nru_pkg::MASK_W) ? ADDR_BITS : nru_pkg::MASK_W;
    localparam int RW = $clog2(GW + 1);

    logic [ADDR_BITS-1:0] a;
    logic [ADDR_BITS-1:0] keep;
    logic [ADDR_BITS-1:0] used;
    logic [GW-1:0]        sel;
    logic [RW-1:0]        rank [GW];
    logic [SET_W-1:0]     set_acc;

    // rank of each selected bit among the selected bits below it
    always_comb
    begin
        a = ADDR_BITS'(addr);
        for (int b = 0; b < ADDR_BITS; b++)
        begin
            keep[b] = (b >= int'(cfg.offset_bits));
        end
        for (int b = 0; b < GW; b++)
        begin
            sel[b] = cfg.index_mask[b] & keep[b];
        end
        for (int b = 0; b < GW; b++)
        begin
            rank[b] = RW'($countones(sel & GW'((64'(1) << b) - 64'(1))));
        end
        used = '0;
        for (int b = 0; b < GW; b++)
        begin
            used[b] = sel[b] && (int'(rank[b]) < SET_BITS);
        end
        set_acc = '0;
        for (int k = 0; k < SET_BITS; k++)
        begin
            for (int b = 0; b < GW; b++)
            begin
                if (sel[b] && int'(rank[b]) == k && a[b])
                begin
                    set_acc[k] = 1'b1;
                end
            end
        end
    end

    assign set_idx = set_acc;
    assign tag = a & keep & ~used;

endmodule

[hw/rtl/nru_store.sv]
module nru_store #(
    parameter int AW = 10,
    parameter int DEPTH = 1024,
    parameter int TW = 256,
    parameter int MW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          tag_we,
    input  logic          meta_we,
    input  logic [AW-1:0] wr_addr,
    input  logic [TW-1:0] wr_tags,
    input  logic [MW-1:0] wr_meta,
    output logic [TW-1:0] rd_tags,
    output logic [MW-1:0] rd_meta
);

    logic [TW-1:0] tag_mem [DEPTH];
    logic [MW-1:0] meta_mem [DEPTH];

    logic [TW-1:0] tag_q_reg;
    logic [MW-1:0] meta_q_reg;
    logic [TW-1:0] tag_byp_reg;
    logic [MW-1:0] meta_byp_reg;
    logic          tag_fwd_reg;
    logic          tag_fwd_next;
    logic          meta_fwd_reg;
    logic          meta_fwd_next;

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[wr_addr] <= wr_tags;
        end
        if (meta_we)
        begin
            meta_mem[wr_addr] <= wr_meta;
        end
        if (rd_en)
        begin
            tag_q_reg <= tag_mem[rd_addr];
            meta_q_reg <= meta_mem[rd_addr];
            tag_byp_reg <= wr_tags;
            meta_byp_reg <= wr_meta;
        end
    end

    // read during write of the same row returns the new row
    always_comb
    begin
        tag_fwd_next = tag_fwd_reg;
        meta_fwd_next = meta_fwd_reg;
        if (rd_en)
        begin
            tag_fwd_next = tag_we && (wr_addr == rd_addr);
            meta_fwd_next = meta_we && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_fwd_reg <= 1'b0;
            meta_fwd_reg <= 1'b0;
        end
        else
        begin
            tag_fwd_reg <= tag_fwd_next;
            meta_fwd_reg <= meta_fwd_next;
        end
    end

    assign rd_tags = tag_fwd_reg ? tag_byp_reg : tag_q_reg;
    assign rd_meta = meta_fwd_reg ? meta_byp_reg : meta_q_reg;

endmodule

[hw/rtl/nru_update.sv]
module nru_update #(
    parameter int WAYS = 8,
    parameter int ADDR_BITS = 32,
    parameter int WAY_W = 3,
    parameter int NW_W = 4
) (
    input  logic [ADDR_BITS-1:0]            tag,
    input  logic [WAYS-1:0][ADDR_BITS-1:0]  tags_in,
    input  logic [WAYS-1:0]                 valid_in,
    input  logic [WAYS-1:0]                 nru_in,
    input  logic [NW_W-1:0]                 nw,
    output logic                            hit,
    output logic [WAY_W-1:0]                way,
    output logic [WAYS-1:0][ADDR_BITS-1:0]  tags_out,
    output logic [WAYS-1:0]                 valid_out,
    output logic [WAYS-1:0]                 nru_out
);

    logic [WAYS-1:0]  in_use;
    logic [WAYS-1:0]  match;
    logic [WAYS-1:0]  free;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] free_way;
    logic             any_free;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            in_use[w] = (w < int'(nw));
            match[w] = in_use[w] && valid_in[w] && (tags_in[w] == tag);
            free[w] = in_use[w] && nru_in[w];
        end
        hit = |match;
        any_free = |free;
        hit_way = '0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (free[w])
            begin
                free_way = WAY_W'(w);
            end
        end

        tags_out = tags_in;
        valid_out = valid_in;
        nru_out = nru_in;
        way = hit_way;
        if (hit)
        begin
            nru_out = nru_in & ~match;
        end
        else
        begin
            if (!any_free)
            begin
                nru_out = nru_in | in_use;
                way = '0;
            end
            else
            begin
                way = free_way;
            end
            for (int w = 0; w < WAYS; w++)
            begin
                if (WAY_W'(w) == way)
                begin
                    tags_out[w] = tag;
                    valid_out[w] = 1'b1;
                    nru_out[w] = 1'b0;
                end
            end
        end
    end

endmodule
